[rtl/sha1_message_digest_core_macros.svh]
// Assertion macros for the SHA-1 digest core.
// Included by files that carry concurrent assertions; needs no package.
`ifndef SHA1_MESSAGE_DIGEST_CORE_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SHA1MD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SHA1MD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SHA1MD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SHA1MD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/sha1md_pkg.sv]
// Shared types and constants of the SHA-1 digest core.
// Used by the round function and the top level; depends on nothing.
package sha1md_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} vars_t;

	localparam logic [31:0] K_R0 = 32'h5A827999;
	localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R3 = 32'hCA62C1D6;

	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [6:0] RND_B1   = 7'd20;
	localparam logic [6:0] RND_B2   = 7'd40;
	localparam logic [6:0] RND_B3   = 7'd60;
	localparam logic [6:0] RND_LAST = 7'd79;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [5:0] BYTE_LAST = 6'd63;
	localparam logic [2:0] WORD_LAST = 3'd4;

endpackage

[rtl/sha1md_round.sv]
// One SHA-1 compression round, shared by all 80 rounds of a block.
// Depends on sha1md_pkg for the working variable type and round constants.
module sha1md_round import sha1md_pkg::*; (
	input  vars_t       cur,
	input  logic [31:0] w,
	input  logic [6:0]  round,
	output vars_t       nxt
);

	logic [31:0] f;
	logic [31:0] k;

	always_comb begin
		if (round < RND_B1) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = K_R0;
		end else if (round < RND_B2) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_R1;
		end else if (round < RND_B3) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = K_R2;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_R3;
		end
	end

	assign nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;
	assign nxt.b = cur.a;
	assign nxt.c = {cur.b[1:0], cur.b[31:2]};
	assign nxt.d = cur.c;
	assign nxt.e = cur.d;

endmodule

[rtl/sha1_message_digest_core.sv]
// Top level of the SHA-1 digest core: byte intake, padding, round sequencer, digest output.
// Depends on sha1md_pkg, sha1md_round and sha1_message_digest_core_macros.svh.
//
// channel  direction  beat                                       handshake
// input    in         data_byte, byte_valid, end_of_message      in_valid / in_stall
// output   out        digest_word, word_index, last_word         out_valid / out_stall
//
// A byte beat is taken in the idle state; the beat that fills a 64-byte block starts
// the 80 rounds on the shared round unit and then the hash update.
// The end beat pads one byte per cycle up to the block end, compresses one or two
// blocks, then offers five digest beats. in_stall is high after a block-filling beat
// until its hash update is done, and after an end beat until the last digest beat is
// taken. Reset loads the initial hash and clears the bit count; no clearing pass is needed.
`include "sha1_message_digest_core_macros.svh"
module sha1_message_digest_core import sha1md_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	state_t      state_q;
	state_t      state_d;
	logic [31:0] h_q [5];
	logic [63:0] bit_count_q;
	logic [511:0] win_q;
	vars_t       vars_q;
	vars_t       vars_nxt;
	logic [6:0]  round_q;
	logic [5:0]  pos_q;
	logic        first_q;
	logic        len_ok_q;
	logic        len_done_q;
	logic        fin_pend_q;
	logic        pad_act_q;
	logic [2:0]  widx_q;

	logic        in_acc;
	logic        out_acc;
	logic [5:0]  bc_idx;
	logic [5:0]  pos_new;
	logic        blk_full;
	logic [31:0] w_mix;
	logic [31:0] w_new;
	logic [7:0]  pad_byte;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;
	assign bc_idx   = bit_count_q[8:3];
	assign pos_new  = bc_idx + {5'b0, byte_valid};
	assign blk_full = byte_valid && (bc_idx == BYTE_LAST);

	assign w_mix = win_q[95:64] ^ win_q[255:224] ^ win_q[447:416] ^ win_q[511:480];
	assign w_new = {w_mix[30:0], w_mix[31]};

	always_comb begin
		if (first_q) begin
			pad_byte = PAD_BYTE;
		end else if (len_ok_q && (pos_q >= LEN_POS)) begin
			pad_byte = bit_count_q[{~pos_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	sha1md_round u_round (
		.cur   (vars_q),
		.w     (win_q[511:480]),
		.round (round_q),
		.nxt   (vars_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_acc) begin
					if (blk_full) begin
						state_d = ST_ROUND;
					end else if (end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_ROUND: begin
				if (round_q == RND_LAST) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (pad_act_q) begin
					state_d = len_done_q ? ST_OUT : ST_PAD;
				end else begin
					state_d = fin_pend_q ? ST_PAD : ST_IDLE;
				end
			end
			ST_PAD: begin
				if (pos_q == BYTE_LAST) begin
					state_d = ST_ROUND;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_acc && (widx_q == WORD_LAST)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q         <= H_INIT;
			bit_count_q <= '0;
			round_q     <= '0;
			pos_q       <= '0;
			first_q     <= 1'b0;
			len_ok_q    <= 1'b0;
			len_done_q  <= 1'b0;
			fin_pend_q  <= 1'b0;
			pad_act_q   <= 1'b0;
			widx_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (byte_valid) begin
							bit_count_q <= bit_count_q + 64'd8;
						end
						fin_pend_q <= end_of_message;
						pad_act_q  <= end_of_message && !blk_full;
						pos_q      <= pos_new;
						first_q    <= 1'b1;
						len_ok_q   <= pos_new < LEN_POS;
						len_done_q <= 1'b0;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 7'd1;
				end
				ST_ADD: begin
					h_q[0]  <= h_q[0] + vars_q.a;
					h_q[1]  <= h_q[1] + vars_q.b;
					h_q[2]  <= h_q[2] + vars_q.c;
					h_q[3]  <= h_q[3] + vars_q.d;
					h_q[4]  <= h_q[4] + vars_q.e;
					if (pad_act_q && !len_done_q) begin
						pos_q    <= '0;
						first_q  <= 1'b0;
						len_ok_q <= 1'b1;
					end else if (!pad_act_q && fin_pend_q) begin
						pos_q      <= '0;
						first_q    <= 1'b1;
						len_ok_q   <= 1'b1;
						len_done_q <= 1'b0;
						pad_act_q  <= 1'b1;
						fin_pend_q <= 1'b0;
					end
				end
				ST_PAD: begin
					pos_q   <= pos_q + 6'd1;
					first_q <= 1'b0;
					if (pos_q == BYTE_LAST) begin
						len_done_q <= len_ok_q;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						if (widx_q == WORD_LAST) begin
							widx_q      <= '0;
							h_q         <= H_INIT;
							bit_count_q <= '0;
							pad_act_q   <= 1'b0;
						end else begin
							widx_q <= widx_q + 3'd1;
						end
					end
				end
				default: begin
				end
			endcase
			if ((state_d == ST_ROUND) && (state_q != ST_ROUND)) begin
				round_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_acc && byte_valid) begin
			win_q <= {win_q[503:0], data_byte};
		end else if (state_q == ST_PAD) begin
			win_q <= {win_q[503:0], pad_byte};
		end else if (state_q == ST_ROUND) begin
			win_q <= {win_q[479:0], w_new};
		end
		if ((state_d == ST_ROUND) && (state_q != ST_ROUND)) begin
			vars_q <= '{a: h_q[0], b: h_q[1], c: h_q[2], d: h_q[3], e: h_q[4]};
		end else if (state_q == ST_ROUND) begin
			vars_q <= vars_nxt;
		end
	end

	assign digest_word = h_q[widx_q];
	assign word_index  = widx_q;
	assign last_word   = widx_q == WORD_LAST;

	`SHA1MD_ASSERT_IMP(a_widx_range, clk, arst_n, state_q == ST_OUT, widx_q <= WORD_LAST,
		"digest word index out of range")
	`SHA1MD_ASSERT_IMP(a_round_range, clk, arst_n, state_q == ST_ROUND, round_q <= RND_LAST,
		"round counter past last round")
	`SHA1MD_ASSERT_NXT(a_end_starts, clk, arst_n, in_acc && end_of_message,
		(state_q == ST_PAD) || (state_q == ST_ROUND), "end beat did not start padding")
	`SHA1MD_ASSERT_NXT(a_msg_clear, clk, arst_n, out_acc && last_word,
		(bit_count_q == 64'd0) && (state_q == ST_IDLE), "message state not cleared")

endmodule
